>>> rtl/lsp_pkg.sv
// ============================================================================
// lsp_pkg
// Shared codes and widths for the looping sample player.
// ============================================================================
`default_nettype none

package lsp_pkg;

    localparam int OP_W   = 3;
    localparam int SMP_W  = 16;
    localparam int PH_W   = 15;
    localparam int ADDR_W = 14;
    localparam int CNT_W  = 4;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [1:0]      xport_t;
    typedef logic [2:0]      reg_idx_t;

    localparam op_t OP_LOAD  = 3'd0;
    localparam op_t OP_TICK  = 3'd1;
    localparam op_t OP_PLAY  = 3'd2;
    localparam op_t OP_PAUSE = 3'd3;
    localparam op_t OP_STOP  = 3'd4;
    localparam op_t OP_SEEK  = 3'd5;

    localparam xport_t XP_STOPPED = 2'd0;
    localparam xport_t XP_PLAYING = 2'd1;
    localparam xport_t XP_PAUSED  = 2'd2;

    localparam reg_idx_t REG_BUFFER_LENGTH   = 3'd0;
    localparam reg_idx_t REG_SOURCE_CHANNELS = 3'd1;
    localparam reg_idx_t REG_OUTPUT_CHANNELS = 3'd2;
    localparam reg_idx_t REG_LOOPING         = 3'd3;
    localparam reg_idx_t REG_GAIN            = 3'd4;
    localparam reg_idx_t REG_ROUTING         = 3'd5;

    localparam logic [3:0] ROUTE_SAME = 4'd14;
    localparam logic [3:0] ROUTE_MUTE = 4'd15;

    localparam logic [PH_W-1:0] RST_BUFFER_LENGTH   = 15'd16384;
    localparam logic [3:0]      RST_SOURCE_CHANNELS = 4'd1;
    localparam logic [3:0]      RST_OUTPUT_CHANNELS = 4'd2;
    localparam logic [15:0]     RST_GAIN            = 16'd4096;
    localparam logic [31:0]     RST_ROUTING         = 32'h7654_3210;

endpackage

`default_nettype wire

>>> rtl/looping_sample_player.sv
// ============================================================================
// looping_sample_player
// Sample playback voice with loop, transport control and channel routing.
// ============================================================================
// Load, play, pause, stop and seek transactions are taken in the idle state and
// leave it idle. A playing tick reads one sample memory entry per cycle (nrd
// reads: one for a mono source, else one per source channel), waits in the drain
// state for the last read, then takes each output channel through the gain
// multiply and the round/saturate stage, which holds while the output stalls. A
// silent tick skips the reads. No transaction is taken until the sequencer is
// idle again; reads share one memory read port, outputs one gain multiplier.
`default_nettype none

module looping_sample_player
    import lsp_pkg::*;
#(
    parameter int MAX_FRAMES          = 16384,
    parameter int MAX_SOURCE_CHANNELS = 8,
    parameter int MAX_OUTPUT_CHANNELS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // load_channel[2:0], load_address[16:3], load_value[32:17], seek_position[46:33]
    input  wire logic [47:0] s_axis_tdata,
    // op[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sample[15:0], play_state[17:16], playhead[32:18]
    output logic      [39:0] m_axis_tdata,
    // dst_channel[2:0]
    output logic      [2:0]  m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int FR_CAP      = (MAX_FRAMES > 32767) ? 32767 : MAX_FRAMES;
    localparam int FRAME_DEPTH = (MAX_FRAMES > 16384) ? 16384 : MAX_FRAMES;
    localparam int FA_W        = $clog2(FRAME_DEPTH);
    localparam int CH_W        = (MAX_SOURCE_CHANNELS > 1) ? $clog2(MAX_SOURCE_CHANNELS) : 1;
    localparam int OC_W        = (MAX_OUTPUT_CHANNELS > 1) ? $clog2(MAX_OUTPUT_CHANNELS) : 1;
    localparam int MEM_DEPTH   = 2 ** (FA_W + CH_W);
    localparam int ACC_W       = SMP_W + 3;
    localparam int PROD_W      = ACC_W + 17;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_RND   = 3'd4;

    // configuration
    logic [PH_W-1:0] buffer_length_reg;
    logic [3:0]      source_channels_reg;
    logic [3:0]      output_channels_reg;
    logic            looping_reg;
    logic [15:0]     gain_reg;
    logic [31:0]     routing_reg;

    logic     cfg_we;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg   <= RST_BUFFER_LENGTH;
            source_channels_reg <= RST_SOURCE_CHANNELS;
            output_channels_reg <= RST_OUTPUT_CHANNELS;
            looping_reg         <= 1'b0;
            gain_reg            <= RST_GAIN;
            routing_reg         <= RST_ROUTING;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_BUFFER_LENGTH:   buffer_length_reg   <= pwdata[PH_W-1:0];
                REG_SOURCE_CHANNELS: source_channels_reg <= pwdata[3:0];
                REG_OUTPUT_CHANNELS: output_channels_reg <= pwdata[3:0];
                REG_LOOPING:         looping_reg         <= pwdata[0];
                REG_GAIN:            gain_reg            <= pwdata[15:0];
                REG_ROUTING:         routing_reg         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BUFFER_LENGTH:   prdata = {17'd0, buffer_length_reg};
            REG_SOURCE_CHANNELS: prdata = {28'd0, source_channels_reg};
            REG_OUTPUT_CHANNELS: prdata = {28'd0, output_channels_reg};
            REG_LOOPING:         prdata = {31'd0, looping_reg};
            REG_GAIN:            prdata = {16'd0, gain_reg};
            REG_ROUTING:         prdata = routing_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // derived settings
    logic [PH_W-1:0] len;
    logic [3:0]      nsrc;
    logic [3:0]      nout;
    logic [3:0]      nrd;
    logic            mono;

    always_comb
    begin
        len  = (buffer_length_reg > PH_W'(FR_CAP)) ? PH_W'(FR_CAP) : buffer_length_reg;
        nsrc = (source_channels_reg > 4'(MAX_SOURCE_CHANNELS)) ?
               4'(MAX_SOURCE_CHANNELS) : source_channels_reg;
        nout = (output_channels_reg > 4'(MAX_OUTPUT_CHANNELS)) ?
               4'(MAX_OUTPUT_CHANNELS) : output_channels_reg;
        mono = (nsrc <= 4'd1);
        nrd  = mono ? 4'd1 : nsrc;
    end

    // input unpacking
    op_t               in_op;
    logic [2:0]        in_ch;
    logic [ADDR_W-1:0] in_addr;
    logic [SMP_W-1:0]  in_value;
    logic [ADDR_W-1:0] in_seek;
    logic              in_xfer;

    assign in_op    = s_axis_tuser;
    assign in_ch    = s_axis_tdata[2:0];
    assign in_addr  = s_axis_tdata[16:3];
    assign in_value = s_axis_tdata[32:17];
    assign in_seek  = s_axis_tdata[46:33];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    // control state
    logic [2:0]      fsm_reg, fsm_next;
    xport_t          xport_reg;
    logic [PH_W-1:0] playhead_reg;
    logic [PH_W-1:0] rd_frame_reg;
    logic [CNT_W-1:0] ch_cnt_reg;
    logic [CNT_W-1:0] oc_cnt_reg;
    logic [CH_W-1:0]  rch_reg;
    logic             rvld_reg;

    logic tick_go;
    logic tick_play;
    logic out_load;
    logic out_last_next;

    assign s_axis_tready = (fsm_reg == S_IDLE);
    assign tick_go       = in_xfer && (in_op == OP_TICK);
    assign tick_play     = (xport_reg == XP_PLAYING) && (playhead_reg < len);
    assign out_load      = (fsm_reg == S_RND) && (!m_axis_tvalid || m_axis_tready);
    assign out_last_next = ((oc_cnt_reg + 4'd1) == nout);

    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (tick_go)
                begin
                    if (tick_play)
                        fsm_next = S_RD;
                    else if (nout != 4'd0)
                        fsm_next = S_MUL;
                end
            end
            S_RD:
            begin
                if ((ch_cnt_reg + 4'd1) == nrd)
                    fsm_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                fsm_next = (nout != 4'd0) ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                fsm_next = S_RND;
            end
            S_RND:
            begin
                if (out_load)
                    fsm_next = out_last_next ? S_IDLE : S_MUL;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= S_IDLE;
            xport_reg    <= XP_STOPPED;
            playhead_reg <= '0;
            ch_cnt_reg   <= '0;
            oc_cnt_reg   <= '0;
            rvld_reg     <= 1'b0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            rvld_reg <= (fsm_reg == S_RD);

            if (in_xfer)
            begin
                unique case (in_op)
                    OP_PLAY:  xport_reg <= XP_PLAYING;
                    OP_PAUSE: xport_reg <= XP_PAUSED;
                    OP_STOP:
                    begin
                        xport_reg    <= XP_STOPPED;
                        playhead_reg <= '0;
                    end
                    OP_SEEK:
                    begin
                        if ({1'b0, in_seek} < len)
                            playhead_reg <= {1'b0, in_seek};
                    end
                    OP_TICK:
                    begin
                        if (tick_play)
                        begin
                            if ((playhead_reg + PH_W'(1)) < len)
                                playhead_reg <= playhead_reg + PH_W'(1);
                            else
                            begin
                                playhead_reg <= '0;
                                if (!looping_reg)
                                    xport_reg <= XP_STOPPED;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (tick_go)
            begin
                ch_cnt_reg <= '0;
                oc_cnt_reg <= '0;
            end
            else if (fsm_reg == S_RD)
                ch_cnt_reg <= ch_cnt_reg + 4'd1;
            else if (out_load)
                oc_cnt_reg <= oc_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
            rd_frame_reg <= playhead_reg;
        if (fsm_reg == S_RD)
            rch_reg <= ch_cnt_reg[CH_W-1:0];
    end

    // sample memory
    logic [SMP_W-1:0] mem [MEM_DEPTH];
    logic [SMP_W-1:0] rdata_reg;
    logic             mem_we;
    logic             mem_re;
    logic [FA_W+CH_W-1:0] waddr;
    logic [FA_W+CH_W-1:0] raddr;

    assign mem_we = in_xfer && (in_op == OP_LOAD)
                    && ({1'b0, in_ch} < 4'(MAX_SOURCE_CHANNELS))
                    && ({1'b0, in_addr} < PH_W'(FR_CAP));
    assign mem_re = (fsm_reg == S_RD);
    assign waddr  = {in_addr[FA_W-1:0], CH_W'(in_ch)};
    assign raddr  = {rd_frame_reg[FA_W-1:0], ch_cnt_reg[CH_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= in_value;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    // routing and accumulation
    logic signed [ACC_W-1:0] acc [MAX_OUTPUT_CHANNELS];
    logic signed [ACC_W-1:0] rd_ext;
    logic [3:0]              code;
    logic [3:0]              tgt;
    logic                    route_ok;

    always_comb
    begin
        rd_ext   = ACC_W'($signed(rdata_reg));
        code     = routing_reg[{rch_reg, 2'b00} +: 4];
        tgt      = (code == ROUTE_SAME) ? 4'(rch_reg) : code;
        route_ok = (code != ROUTE_MUTE) && (tgt < nout);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_OUTPUT_CHANNELS; k++)
        begin
            if (tick_go)
                acc[k] <= '0;
            else if (rvld_reg)
            begin
                if (mono)
                    acc[k] <= rd_ext;
                else if (route_ok && (tgt == 4'(k)))
                    acc[k] <= acc[k] + rd_ext;
            end
        end
    end

    // gain, rounding and saturation
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_neg;
    logic [PROD_W-2:0]        mag;
    logic [PROD_W-2:0]        mag_rnd;
    logic [PROD_W-14:0]       qmag;
    logic [SMP_W-1:0]         sat_val;

    always_ff @(posedge clk)
    begin
        if (fsm_reg == S_MUL)
            prod_reg <= acc[oc_cnt_reg[OC_W-1:0]] * $signed({1'b0, gain_reg});
    end

    always_comb
    begin
        prod_neg = -prod_reg;
        mag      = prod_reg[PROD_W-1] ? prod_neg[PROD_W-2:0] : prod_reg[PROD_W-2:0];
        mag_rnd  = mag + (PROD_W-1)'(2048);
        qmag     = mag_rnd[PROD_W-2:12];
        if (!prod_reg[PROD_W-1])
            sat_val = (qmag > (PROD_W-13)'(32767)) ? 16'h7FFF : qmag[SMP_W-1:0];
        else
            sat_val = (qmag > (PROD_W-13)'(32768)) ? 16'h8000 : (16'd0 - qmag[SMP_W-1:0]);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (out_load)
            m_axis_tvalid <= 1'b1;
        else if (m_axis_tready)
            m_axis_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_axis_tdata <= {7'd0, playhead_reg, xport_reg, sat_val};
            m_axis_tuser <= oc_cnt_reg[2:0];
            m_axis_tlast <= out_last_next;
        end
    end

    // checks
    a_mem_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("sample memory written and read in the same cycle");

    a_rdata_src: assert property (@(posedge clk) disable iff (!rst_n)
        rvld_reg |-> ($past(fsm_reg) == S_RD))
        else $error("read data flagged without a read");

    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_RD) |-> (ch_cnt_reg < nrd))
        else $error("channel read counter past source count");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (fsm_reg == S_IDLE))
        else $error("sequencer not idle after last channel of frame");

endmodule

`default_nettype wire

>>> bench/tb_looping_sample_player.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_looping_sample_player
// Self-checking bench for the looping sample player.
// ============================================================================
// Drives load, transport and tick transactions on the input stream and
// registers over APB. A shadow of the voice (sample memory, playhead,
// transport state, registers) predicts every output frame; a monitor compares
// each output transaction with the oldest prediction. Directed tests cover
// transport, routing, gain and saturation, then backpressure, then random
// phases sweep the register settings. Both stream sides idle at random.

module tb_looping_sample_player
    import lsp_pkg::*;
;

    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  SETTLE      = 64;
    localparam op_t OP_RSVD6    = 3'd6;
    localparam op_t OP_RSVD7    = 3'd7;
    localparam logic [3:0] ROUTE_DROP = 4'd9;

    typedef struct packed {
        logic [2:0]  chan;
        logic [15:0] smp;
        logic        last;
        xport_t      pstate;
        logic [14:0] phead;
    } out_frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // load_channel[2:0], load_address[16:3], load_value[32:17], seek_position[46:33]
    logic [47:0] s_axis_tdata = '0;
    // op[2:0]
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // sample[15:0], play_state[17:16], playhead[32:18]
    logic [39:0] m_axis_tdata;
    // dst_channel[2:0]
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    looping_sample_player DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow of the voice
    logic [15:0]  voice_mem     [0:131071];
    bit           voice_mem_set [0:131071];
    int unsigned  play_pos = 0;
    xport_t       xport = XP_STOPPED;
    logic [14:0]  cfg_len   = RST_BUFFER_LENGTH;
    logic [3:0]   cfg_nsrc  = RST_SOURCE_CHANNELS;
    logic [3:0]   cfg_nout  = RST_OUTPUT_CHANNELS;
    logic         cfg_loop  = 1'b0;
    logic [15:0]  cfg_gain  = RST_GAIN;
    logic [31:0]  cfg_route = RST_ROUTING;

    out_frame_t expected_frames [$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_jitter = 1'b1;
    bit  rx_jitter = 1'b1;
    int  rx_hold_req = 0;
    int  rx_stall = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned eff_length();
        return (cfg_len > 15'd16384) ? 16384 : cfg_len;
    endfunction

    function automatic int unsigned source_count();
        if (cfg_nsrc <= 4'd1) return 1;
        return (cfg_nsrc > 4'd8) ? 8 : cfg_nsrc;
    endfunction

    function automatic logic [15:0] scale_to_q15(longint sum);
        longint p;
        longint q;
        p = sum * longint'(cfg_gain);
        if (p >= 0) q = (p + 2048) / 4096;
        else        q = -((-p + 2048) / 4096);
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Updates the shadow for one accepted transaction and queues the frames it causes.
    function automatic void advance_player(op_t op, logic [2:0] lch, logic [13:0] laddr,
                                           logic [15:0] lval, logic [13:0] spos);
        int unsigned len;
        int unsigned nout;
        int unsigned nsrc;
        int unsigned pos;
        int unsigned tgt;
        logic [3:0]  code;
        longint      acc [8];
        out_frame_t  f;
        len = eff_length();
        case (op)
            OP_LOAD:
            begin
                voice_mem[{laddr, lch}] = lval;
                voice_mem_set[{laddr, lch}] = 1'b1;
            end
            OP_PLAY:  xport = XP_PLAYING;
            OP_PAUSE: xport = XP_PAUSED;
            OP_STOP:
            begin
                xport = XP_STOPPED;
                play_pos = 0;
            end
            OP_SEEK:
            begin
                if (spos < len) play_pos = spos;
            end
            OP_TICK:
            begin
                nout = (cfg_nout > 4'd8) ? 8 : cfg_nout;
                nsrc = source_count();
                for (int k = 0; k < 8; k++) acc[k] = 0;
                if (xport == XP_PLAYING && play_pos < len)
                begin
                    pos = play_pos;
                    if (nsrc == 1)
                    begin
                        for (int k = 0; k < nout; k++)
                            acc[k] = $signed(voice_mem[{pos[13:0], 3'd0}]);
                    end
                    else
                    begin
                        for (int ch = 0; ch < nsrc; ch++)
                        begin
                            code = cfg_route[4*ch +: 4];
                            if (code == ROUTE_MUTE) continue;
                            tgt = (code == ROUTE_SAME) ? ch : code;
                            if (tgt < nout)
                                acc[tgt] += $signed(voice_mem[{pos[13:0], 3'(ch)}]);
                        end
                    end
                    if (pos + 1 < len)
                    begin
                        play_pos = pos + 1;
                    end
                    else
                    begin
                        play_pos = 0;
                        if (!cfg_loop) xport = XP_STOPPED;
                    end
                end
                for (int k = 0; k < nout; k++)
                begin
                    f.chan   = 3'(k);
                    f.smp    = scale_to_q15(acc[k]);
                    f.last   = (k + 1 == nout);
                    f.pstate = xport;
                    f.phead  = 15'(play_pos);
                    expected_frames.push_back(f);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(op_t op, logic [2:0] lch, logic [13:0] laddr,
                             logic [15:0] lval, logic [13:0] spos);
        int gap;
        gap = tx_jitter ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, spos, lval, laddr, lch};
        do @(posedge clk); while (!s_axis_tready);
        advance_player(op, lch, laddr, lval, spos);
    endtask

    task automatic command(op_t op);
        send_item(op, 3'($urandom), 14'($urandom), 16'($urandom), 14'($urandom));
    endtask

    task automatic load_sample(logic [2:0] ch, logic [13:0] addr, logic [15:0] value);
        send_item(OP_LOAD, ch, addr, value, 14'($urandom));
    endtask

    task automatic seek_to(logic [13:0] pos);
        send_item(OP_SEEK, 3'($urandom), 14'($urandom), 16'($urandom), pos);
    endtask

    // Fills any unwritten entry the next tick would read, then sends the tick.
    task automatic send_tick();
        int unsigned nsrc;
        if (xport == XP_PLAYING && play_pos < eff_length())
        begin
            nsrc = source_count();
            for (int c = 0; c < nsrc; c++)
                if (!voice_mem_set[{play_pos[13:0], 3'(c)}])
                    load_sample(3'(c), play_pos[13:0], random_sample());
        end
        command(OP_TICK);
    endtask

    task automatic drain();
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BUFFER_LENGTH:   cfg_len   = value[14:0];
            REG_SOURCE_CHANNELS: cfg_nsrc  = value[3:0];
            REG_OUTPUT_CHANNELS: cfg_nout  = value[3:0];
            REG_LOOPING:         cfg_loop  = value[0];
            REG_GAIN:            cfg_gain  = value[15:0];
            REG_ROUTING:         cfg_route = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [14:0] len, logic [3:0] nsrc, logic [3:0] nout,
                                logic lp, logic [15:0] g, logic [31:0] route);
        drain();
        write_reg(REG_BUFFER_LENGTH, 32'(len));
        write_reg(REG_SOURCE_CHANNELS, 32'(nsrc));
        write_reg(REG_OUTPUT_CHANNELS, 32'(nout));
        write_reg(REG_LOOPING, 32'(lp));
        write_reg(REG_GAIN, 32'(g));
        write_reg(REG_ROUTING, route);
    endtask

    // output side: random stalls plus a requested long hold-off
    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_stall = rx_hold_req;
            rx_hold_req = 0;
        end
        else if (rx_stall == 0 && rx_jitter && $urandom_range(0, 99) < 20)
        begin
            rx_stall = 1 + pick_gap();
        end
        if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(string what, out_frame_t want);
        error_count++;
        if (error_count <= 10)
        begin
            $display("[%0t] %s: exp ch=%0d smp=%h last=%b st=%0d ph=%0d",
                     $realtime, what, want.chan, want.smp, want.last, want.pstate,
                     want.phead);
            $display("    got ch=%0d smp=%h last=%b st=%0d ph=%0d",
                     m_axis_tuser, m_axis_tdata[15:0], m_axis_tlast, m_axis_tdata[17:16],
                     m_axis_tdata[32:18]);
        end
    endtask

    always @(posedge clk)
    begin
        out_frame_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_frames.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected transaction", want);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (m_axis_tuser !== want.chan || m_axis_tdata[15:0] !== want.smp ||
                    m_axis_tlast !== want.last || m_axis_tdata[17:16] !== want.pstate ||
                    m_axis_tdata[32:18] !== want.phead)
                    note_mismatch("field mismatch", want);
            end
        end
    end

    // defaults: mono, two outputs, full-size buffer, no loop
    task automatic test_transport_defaults();
        send_tick();
        command(OP_RSVD6);
        command(OP_RSVD7);
        load_sample(3'd0, 14'd0, 16'h7FFF);
        load_sample(3'd0, 14'd16383, 16'h8000);
        load_sample(3'd7, 14'd16383, 16'h8000);
        seek_to(14'd16383);
        send_tick();
        command(OP_PLAY);
        send_tick();
        send_tick();
        command(OP_PLAY);
        send_tick();
        command(OP_PAUSE);
        send_tick();
        seek_to(14'd5);
        command(OP_STOP);
        send_tick();
    endtask

    task automatic test_routing_and_gain();
        apply_config(15'd3, 4'd8, 4'd8, 1'b1, 16'hFFFF,
                     {ROUTE_MUTE, ROUTE_SAME, 4'd3, ROUTE_DROP, 4'd0, 4'd0, 4'd0, 4'd0});
        command(OP_STOP);
        for (int c = 0; c < 8; c++) load_sample(3'(c), 14'd0, 16'h7FFF);
        for (int c = 0; c < 8; c++) load_sample(3'(c), 14'd1, 16'h8000);
        command(OP_PLAY);
        repeat (4) send_tick();
        drain();
        write_reg(REG_GAIN, 32'd2048);
        // half-LSB results: rounding ties go away from zero
        load_sample(3'd0, 14'd0, 16'd1);
        load_sample(3'd1, 14'd0, 16'd0);
        load_sample(3'd2, 14'd0, 16'd0);
        load_sample(3'd3, 14'd0, 16'd0);
        load_sample(3'd5, 14'd0, 16'hFFFF);
        load_sample(3'd6, 14'd0, 16'd3);
        seek_to(14'd0);
        send_tick();
    endtask

    task automatic test_backpressure();
        apply_config(15'd16, 4'd2, 4'd8, 1'b1, RST_GAIN, RST_ROUTING);
        command(OP_STOP);
        command(OP_PLAY);
        tx_jitter = 1'b0;
        rx_hold_req = 400;
        repeat (24) send_tick();
        // hold the input until every frame is out
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (8) send_tick();
        tx_jitter = 1'b1;
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) send_tick();
        else if (r < 63)
        begin
            if ($urandom_range(0, 9) < 7)
                load_sample(3'($urandom), 14'($urandom_range(0, 31)), random_sample());
            else
                load_sample(3'($urandom), 14'($urandom), random_sample());
        end
        else if (r < 75) command(OP_PLAY);
        else if (r < 80) command(OP_PAUSE);
        else if (r < 86) command(OP_STOP);
        else if (r < 97)
        begin
            if (eff_length() > 0 && $urandom_range(0, 9) < 7)
                seek_to(14'($urandom_range(0, eff_length() - 1)));
            else
                seek_to(14'($urandom));
        end
        else command(($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7);
    endtask

    task automatic test_random_phases();
        logic [14:0] len;
        logic [31:0] route;
        int r;
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 0)
            begin
                apply_config(15'd0, 4'd0, 4'd0, 1'b0, 16'h0000, 32'h0000_0000);
            end
            else if (phase == 1)
            begin
                apply_config(15'h7FFF, 4'hF, 4'hF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)      len = 15'($urandom_range(1, 24));
                else if (r < 70) len = 15'($urandom_range(0, 100));
                else             len = 15'($urandom_range(16000, 32767));
                for (int c = 0; c < 8; c++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)      route[4*c +: 4] = 4'(c);
                    else if (r < 60) route[4*c +: 4] = ROUTE_SAME;
                    else if (r < 75) route[4*c +: 4] = ROUTE_MUTE;
                    else             route[4*c +: 4] = 4'($urandom);
                end
                apply_config(len,
                             ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)),
                             ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)),
                             1'($urandom),
                             ($urandom_range(0, 2) == 0) ? RST_GAIN : 16'($urandom),
                             route);
            end
            tx_jitter = ($urandom_range(0, 9) < 7);
            rx_jitter = ($urandom_range(0, 9) < 7);
            command(OP_PLAY);
            repeat (20) random_item();
        end
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        test_transport_defaults();
        test_routing_and_gain();
        test_backpressure();
        test_random_phases();
        drain();
        if (error_count == 0 && expected_frames.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
